FILE: rtl/core/ashrx_pkg.sv
// Shared types, byte codes and helper functions for the ASH receive deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ashrx_pkg;

    localparam logic [7:0] MAX_PAYLOAD = 8'd128;

    localparam logic [7:0] BYTE_FLAG   = 8'h7E;
    localparam logic [7:0] BYTE_CANCEL = 8'h1A;
    localparam logic [7:0] BYTE_SUB    = 8'h18;
    localparam logic [7:0] BYTE_XON    = 8'h11;
    localparam logic [7:0] BYTE_XOFF   = 8'h13;
    localparam logic [7:0] BYTE_ESC    = 8'h7D;
    localparam logic [7:0] ESC_FLIP    = 8'h20;

    localparam logic [7:0]  CTRL_RST_ACK = 8'hC1;
    localparam logic [7:0]  CTRL_ERROR   = 8'hC2;
    localparam logic [7:0]  CTRL_KIND_MASK = 8'h60;
    localparam logic [7:0]  CTRL_KIND_NAK  = 8'h20;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  LFSR_SEED = 8'h42;
    localparam logic [7:0]  LFSR_TAPS = 8'hB8;

    localparam logic [2:0] TYPE_DATA    = 3'd0;
    localparam logic [2:0] TYPE_ACK     = 3'd1;
    localparam logic [2:0] TYPE_NAK     = 3'd2;
    localparam logic [2:0] TYPE_RST_ACK = 3'd3;
    localparam logic [2:0] TYPE_ERROR   = 3'd4;
    localparam logic [2:0] TYPE_UNKNOWN = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_TRUNCATED = 3'd2;
    localparam logic [2:0] ST_CRC       = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
    localparam logic [2:0] ST_UNKNOWN   = 3'd5;
    localparam logic [2:0] ST_DISCARDED = 3'd6;
    localparam logic [2:0] ST_CANCELLED = 3'd7;

    localparam int unsigned TDATA_W = 32;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] control_byte;
        logic [2:0] frm_type;
        logic [7:0] payload_length;
        logic [2:0] status;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [2:0] classify(input logic [7:0] cb);
        logic [2:0] t;
        if (!cb[7]) t = TYPE_DATA;
        else if ((cb & CTRL_KIND_MASK) == 8'h00) t = TYPE_ACK;
        else if ((cb & CTRL_KIND_MASK) == CTRL_KIND_NAK) t = TYPE_NAK;
        else if (cb == CTRL_RST_ACK) t = TYPE_RST_ACK;
        else if (cb == CTRL_ERROR) t = TYPE_ERROR;
        else t = TYPE_UNKNOWN;
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ashrx_frame.sv
// Frame state and per-byte step logic: control codes, unstuffing, CRC,
// two-byte CRC delay, descrambling and the end-of-frame verdict. Uses ashrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ashrx_frame
#(
    parameter logic [7:0] MAX_PAYLOAD = ashrx_pkg::MAX_PAYLOAD
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        rx_byte,
    output logic                   res_valid,
    output ashrx_pkg::result_t     res
);
    import ashrx_pkg::*;

    logic        esc_reg, esc_next;
    logic        discard_reg, discard_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  dly0_reg, dly0_next;
    logic [7:0]  dly1_reg, dly1_next;
    logic [7:0]  scr_reg, scr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        long_reg, long_next;

    logic [7:0]  ub;
    logic        use_byte;
    logic        give_verdict;
    logic [2:0]  vstat;
    logic [2:0]  held_type;

    assign held_type = classify(held_reg);

    always_comb
    begin
        vstat = ST_OK;
        if (discard_reg) vstat = ST_DISCARDED;
        else if (fill_reg == 2'd0 && !esc_reg) vstat = ST_EMPTY;
        else if (fill_reg != 2'd3) vstat = ST_TRUNCATED;
        else if (crc_reg != 16'h0000) vstat = ST_CRC;
        else
        begin
            unique case (held_type)
                TYPE_DATA:
                    vstat = (count_reg == 8'd0 || long_reg) ? ST_BAD_SIZE : ST_OK;
                TYPE_ACK, TYPE_NAK:
                    vstat = (count_reg != 8'd0 || long_reg) ? ST_BAD_SIZE : ST_OK;
                TYPE_RST_ACK, TYPE_ERROR:
                    vstat = (count_reg != 8'd2 || long_reg) ? ST_BAD_SIZE : ST_OK;
                default:
                    vstat = ST_UNKNOWN;
            endcase
        end
    end

    always_comb
    begin
        esc_next     = esc_reg;
        discard_next = discard_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        held_next    = held_reg;
        dly0_next    = dly0_reg;
        dly1_next    = dly1_reg;
        scr_next     = scr_reg;
        fill_next    = fill_reg;
        long_next    = long_reg;
        res_valid    = 1'b0;
        res          = '0;
        use_byte     = 1'b0;
        give_verdict = 1'b0;
        ub           = rx_byte;

        if (step)
        begin
            if (rx_byte == BYTE_FLAG)
            begin
                give_verdict = 1'b1;
                res.status   = vstat;
            end
            else if (rx_byte == BYTE_CANCEL)
            begin
                give_verdict = 1'b1;
                res.status   = ST_CANCELLED;
            end
            else if (rx_byte == BYTE_SUB)
            begin
                discard_next = 1'b1;
            end
            else if (rx_byte == BYTE_XON || rx_byte == BYTE_XOFF || discard_reg)
            begin
                // dropped
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                ub       = rx_byte ^ ESC_FLIP;
                use_byte = 1'b1;
            end
            else if (rx_byte == BYTE_ESC)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                use_byte = 1'b1;
            end
        end

        if (use_byte)
        begin
            crc_next = crc_byte(crc_reg, ub);
            if (fill_reg == 2'd0)
            begin
                dly0_next = ub;
                fill_next = 2'd1;
            end
            else if (fill_reg == 2'd1)
            begin
                dly1_next = ub;
                fill_next = 2'd2;
            end
            else
            begin
                dly0_next = dly1_reg;
                dly1_next = ub;
                if (fill_reg == 2'd2)
                begin
                    held_next = dly0_reg;
                    fill_next = 2'd3;
                end
                else if (count_reg >= MAX_PAYLOAD)
                begin
                    long_next = 1'b1;
                end
                else
                begin
                    count_next    = count_reg + 8'd1;
                    scr_next      = scr_reg[0] ? ({1'b0, scr_reg[7:1]} ^ LFSR_TAPS)
                                               : {1'b0, scr_reg[7:1]};
                    res_valid     = 1'b1;
                    res.data_byte = held_reg[7] ? dly0_reg : (dly0_reg ^ scr_reg);
                end
            end
        end

        if (give_verdict)
        begin
            res_valid          = 1'b1;
            res.kind           = 1'b1;
            res.control_byte   = (fill_reg == 2'd3) ? held_reg : 8'h00;
            res.frm_type       = (fill_reg == 2'd3) ? held_type : TYPE_UNKNOWN;
            res.payload_length = (fill_reg == 2'd3) ? count_reg : 8'h00;
            esc_next     = 1'b0;
            discard_next = 1'b0;
            count_next   = 8'h00;
            crc_next     = CRC_INIT;
            held_next    = 8'h00;
            scr_next     = LFSR_SEED;
            fill_next    = 2'd0;
            long_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg     <= 1'b0;
            discard_reg <= 1'b0;
            count_reg   <= 8'h00;
            crc_reg     <= CRC_INIT;
            held_reg    <= 8'h00;
            scr_reg     <= LFSR_SEED;
            fill_reg    <= 2'd0;
            long_reg    <= 1'b0;
        end
        else
        begin
            esc_reg     <= esc_next;
            discard_reg <= discard_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            held_reg    <= held_next;
            scr_reg     <= scr_next;
            fill_reg    <= fill_next;
            long_reg    <= long_next;
        end
    end

    // CRC delay line holds unstuffed frame bytes, no reset
    always_ff @(posedge clk)
    begin
        dly0_reg <= dly0_next;
        dly1_reg <= dly1_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/ashrx_out_buf.sv
// Two-entry result queue driving the master-side stream.
// Uses ashrx_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module ashrx_out_buf
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ashrx_pkg::result_t  push_data,
    output logic                     full,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ashrx_pkg::result_t       out_data
);
    import ashrx_pkg::*;

    result_t     slot_reg [2];
    logic        wr_reg, wr_next;
    logic        rd_reg, rd_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ash_receive_deframer_core.sv
// Top level of the ASH receive deframer: input register, frame step logic,
// result queue. Depends on ashrx_pkg, ashrx_frame and ashrx_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// Raw UART bytes enter on the s_ stream, one per transaction; each byte is
// registered, then processed by the frame step logic (control codes, unstuffing,
// CRC-16 CCITT-FALSE, LFSR descrambling). Payload bytes leave on the m_
// stream with m_tlast low as soon as two newer bytes have passed them, so
// they are speculative until the end-of-frame verdict, which carries
// m_tlast high with control byte, type, length and status. Payload bytes
// beyond MAX_PAYLOAD are not emitted and mark the frame as bad size.
// Throughput is one byte per clock; a result passes from the input register
// through the frame step logic into a registered two-entry result queue, which
// lets input continue while a result waits; input stalls only when that queue is full.
module ash_receive_deframer_core
#(
    parameter logic [7:0] MAX_PAYLOAD = ashrx_pkg::MAX_PAYLOAD
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [ashrx_pkg::TDATA_W-1:0] m_tdata,
    // [7:0] data_byte, [15:8] control_byte, [18:16] frm_type,
    // [26:19] payload_length, [29:27] status, [31:30] zero
    output logic             m_tlast    // kind: end-of-frame verdict
);
    import ashrx_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        q_full;
    logic        res_valid;
    result_t     res;
    result_t     head;

    assign advance  = in_valid_reg && !q_full;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    ashrx_frame
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ashrx_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (q_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tlast = head.kind;
    assign m_tdata = {2'b00, head.status, head.payload_length, head.frm_type,
                      head.control_byte, head.data_byte};

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for ash_receive_deframer_core: raw ASH byte streams in, payload
// bytes and frame verdicts out, checked against an in-bench deframer model.
// Depends on ashrx_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_top;

    import ashrx_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef enum int {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_SHORT,
        FLAW_CANCEL,
        FLAW_DISCARD,
        FLAW_DANGLING_ESC
    } flaw_e;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;

    logic        no_gaps;
    int unsigned rx_sent;
    int unsigned mismatch_cnt;
    int unsigned quiet_cycles;

    // deframer model state
    logic        esc_seen;
    logic        hunt_discard;
    logic [7:0]  pay_cnt;
    logic [15:0] crc_acc;
    logic [7:0]  ctl_hold;
    logic [7:0]  dly_bytes [2];
    logic [7:0]  lfsr;
    int unsigned fill_lvl;
    logic        over_limit;

    result_t     decoded_q [$];

    ash_receive_deframer_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic logic [2:0] ctrl_type_of(input logic [7:0] cb);
        if (!cb[7])
            return TYPE_DATA;
        case (cb[6:5])
            2'b00:   return TYPE_ACK;
            2'b01:   return TYPE_NAK;
            default: return (cb == CTRL_RST_ACK) ? TYPE_RST_ACK :
                            (cb == CTRL_ERROR)   ? TYPE_ERROR : TYPE_UNKNOWN;
        endcase
    endfunction

    function automatic logic is_reserved(input logic [7:0] b);
        return b == BYTE_FLAG || b == BYTE_ESC || b == BYTE_XON || b == BYTE_XOFF ||
               b == BYTE_SUB || b == BYTE_CANCEL;
    endfunction

    function automatic void clear_frame_state();
        esc_seen     = 1'b0;
        hunt_discard = 1'b0;
        pay_cnt      = 8'd0;
        crc_acc      = CRC_INIT;
        ctl_hold     = 8'd0;
        lfsr         = LFSR_SEED;
        fill_lvl     = 0;
        over_limit   = 1'b0;
    endfunction

    function automatic void post_verdict(input logic [2:0] st);
        result_t r;
        r.kind           = 1'b1;
        r.data_byte      = 8'd0;
        r.control_byte   = (fill_lvl == 3) ? ctl_hold : 8'd0;
        r.frm_type       = (fill_lvl == 3) ? ctrl_type_of(ctl_hold) : TYPE_UNKNOWN;
        r.payload_length = (fill_lvl == 3) ? pay_cnt : 8'd0;
        r.status         = st;
        decoded_q.push_back(r);
        clear_frame_state();
    endfunction

    function automatic void close_frame();
        if (hunt_discard)
            post_verdict(ST_DISCARDED);
        else if (fill_lvl == 0 && !esc_seen)
            post_verdict(ST_EMPTY);
        else if (fill_lvl < 3)
            post_verdict(ST_TRUNCATED);
        else if (crc_acc != 16'd0)
            post_verdict(ST_CRC);
        else
            case (ctrl_type_of(ctl_hold))
                TYPE_DATA:
                    post_verdict((pay_cnt == 0 || over_limit) ? ST_BAD_SIZE : ST_OK);
                TYPE_ACK, TYPE_NAK:
                    post_verdict((pay_cnt != 0 || over_limit) ? ST_BAD_SIZE : ST_OK);
                TYPE_RST_ACK, TYPE_ERROR:
                    post_verdict((pay_cnt != 2 || over_limit) ? ST_BAD_SIZE : ST_OK);
                default:
                    post_verdict(ST_UNKNOWN);
            endcase
    endfunction

    function automatic void decode_rx_byte(input logic [7:0] raw);
        logic [7:0] b;
        logic [7:0] oldest;
        result_t    r;
        b = raw;
        if (b == BYTE_FLAG)
            close_frame();
        else if (b == BYTE_CANCEL)
            post_verdict(ST_CANCELLED);
        else if (b == BYTE_SUB)
            hunt_discard = 1'b1;
        else if (!(b == BYTE_XON || b == BYTE_XOFF || hunt_discard))
        begin
            if (esc_seen)
            begin
                esc_seen = 1'b0;
                b = b ^ ESC_FLIP;
            end
            else if (b == BYTE_ESC)
            begin
                esc_seen = 1'b1;
                return;
            end
            crc_acc = crc16_next(crc_acc, b);
            if (fill_lvl < 2)
            begin
                dly_bytes[fill_lvl] = b;
                fill_lvl++;
                return;
            end
            oldest       = dly_bytes[0];
            dly_bytes[0] = dly_bytes[1];
            dly_bytes[1] = b;
            if (fill_lvl == 2)
            begin
                ctl_hold = oldest;
                fill_lvl = 3;
            end
            else if (pay_cnt >= MAX_PAYLOAD)
                over_limit = 1'b1;
            else
            begin
                pay_cnt++;
                r                = '0;
                r.data_byte      = ctl_hold[7] ? oldest : (oldest ^ lfsr);
                lfsr             = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                decoded_q.push_back(r);
            end
        end
    endfunction

    // one transaction on the input side; called at a falling edge, returns at one
    task automatic send_byte(input logic [7:0] b);
        if (!no_gaps && $urandom_range(99) < 3)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        decode_rx_byte(b);
        rx_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] ctrl, input int n_pay, input int pay_val,
                              input flaw_e flaw);
        logic [7:0]  body [$];
        logic [15:0] fcs;
        logic [7:0]  b;
        int          cut;
        int          keep;
        body.push_back(ctrl);
        for (int i = 0; i < n_pay; i++)
        begin
            if (pay_val < 0)
                b = 8'($urandom);
            else
                b = 8'(pay_val);
            body.push_back(b);
        end
        fcs = CRC_INIT;
        foreach (body[j])
            fcs = crc16_next(fcs, body[j]);
        body.push_back(fcs[15:8]);
        body.push_back(fcs[7:0]);
        if (flaw == FLAW_CRC)
        begin
            cut = $urandom_range(0, body.size() - 1);
            body[cut] = body[cut] ^ (8'd1 << $urandom_range(0, 7));
        end
        else if (flaw == FLAW_SHORT)
        begin
            keep = $urandom_range(1, 2);
            while (body.size() > keep)
                void'(body.pop_back());
        end
        cut = (flaw == FLAW_CANCEL || flaw == FLAW_DISCARD) ?
              $urandom_range(0, body.size() - 1) : -1;
        for (int i = 0; i < body.size(); i++)
        begin
            if (i == cut)
            begin
                if (flaw == FLAW_CANCEL)
                begin
                    send_byte(BYTE_CANCEL);
                    return;
                end
                send_byte(BYTE_SUB);
            end
            if ($urandom_range(99) < 3)
                send_byte($urandom_range(1) ? BYTE_XON : BYTE_XOFF);
            b = body[i];
            if (is_reserved(b) || ($urandom_range(99) < 4 && !is_reserved(b ^ ESC_FLIP)))
            begin
                send_byte(BYTE_ESC);
                send_byte(b ^ ESC_FLIP);
            end
            else
                send_byte(b);
        end
        if (flaw == FLAW_DANGLING_ESC)
            send_byte(BYTE_ESC);
        send_byte(BYTE_FLAG);
    endtask

    task automatic test_control_codes();
        send_byte(BYTE_FLAG);
        send_byte(BYTE_CANCEL);
        send_byte(BYTE_SUB);
        send_byte(8'h41);
        send_byte(BYTE_FLAG);
        send_byte(BYTE_SUB);
        send_byte(BYTE_CANCEL);
        send_byte(BYTE_ESC);
        send_byte(BYTE_FLAG);
        send_byte(BYTE_XON);
        send_byte(BYTE_XOFF);
        send_byte(BYTE_FLAG);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(BYTE_FLAG);
    endtask

    task automatic test_frame_types();
        send_frame(8'h00, 1, 255, FLAW_NONE);
        send_frame(8'h7F, 1, 0, FLAW_NONE);
        send_frame(8'h80, 0, -1, FLAW_NONE);
        send_frame(CTRL_RST_ACK, 2, -1, FLAW_NONE);
        send_frame(CTRL_ERROR, 1, -1, FLAW_NONE);
    endtask

    task automatic test_payload_limit();
        send_frame(8'h00, int'(MAX_PAYLOAD), -1, FLAW_NONE);
        send_frame(8'h25, int'(MAX_PAYLOAD) + 2, -1, FLAW_NONE);
    endtask

    task automatic test_random_stream();
        int unsigned goal;
        logic [2:0]  ftype;
        logic [7:0]  ctrl;
        int          n_pay;
        int          r;
        flaw_e       flaw;
        goal = rx_sent + 630;
        while (rx_sent < goal)
        begin
            no_gaps = (rx_sent > goal - 450) && (rx_sent < goal - 250);
            if ($urandom_range(99) < 75)
            begin
                ftype = 3'($urandom_range(0, 5));
                r     = $urandom_range(99);
                case (ftype)
                    TYPE_DATA:
                    begin
                        ctrl  = 8'($urandom_range(0, 127));
                        n_pay = (r < 2) ? $urandom_range(126, 131) :
                                (r < 10) ? 0 : $urandom_range(1, 12);
                    end
                    TYPE_ACK, TYPE_NAK:
                    begin
                        ctrl  = ((ftype == TYPE_ACK) ? 8'h80 : 8'hA0) |
                                8'($urandom_range(0, 31));
                        n_pay = (r < 85) ? 0 : $urandom_range(1, 3);
                    end
                    TYPE_RST_ACK, TYPE_ERROR:
                    begin
                        ctrl  = (ftype == TYPE_RST_ACK) ? CTRL_RST_ACK : CTRL_ERROR;
                        n_pay = (r < 80) ? 2 : $urandom_range(0, 4);
                    end
                    default:
                    begin
                        ctrl  = (r < 30) ? 8'hC0 : 8'($urandom_range(8'hC3, 8'hFF));
                        n_pay = $urandom_range(0, 4);
                    end
                endcase
                flaw = ($urandom_range(99) < 70) ? FLAW_NONE : flaw_e'($urandom_range(1, 5));
                send_frame(ctrl, n_pay, -1, flaw);
            end
            else
                repeat ($urandom_range(1, 6))
                begin
                    r = $urandom_range(99);
                    case (1'b1)
                        r < 15:  send_byte(BYTE_FLAG);
                        r < 20:  send_byte(BYTE_CANCEL);
                        r < 25:  send_byte(BYTE_SUB);
                        r < 30:  send_byte(BYTE_ESC);
                        r < 33:  send_byte(BYTE_XON);
                        r < 36:  send_byte(BYTE_XOFF);
                        default: send_byte(8'($urandom_range(0, 255)));
                    endcase
                end
        end
        no_gaps = 1'b0;
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(negedge clk)
        m_tready <= rst_n && (no_gaps || $urandom_range(99) >= 10);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected transaction, expected none, actual tlast=%0b tdata=%h",
                         $time, m_tlast, m_tdata);
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("kind", {7'd0, want.kind}, {7'd0, m_tlast});
                check_field("data_byte", want.data_byte, m_tdata[7:0]);
                check_field("control_byte", want.control_byte, m_tdata[15:8]);
                check_field("frm_type", {5'd0, want.frm_type}, {5'd0, m_tdata[18:16]});
                check_field("payload_length", want.payload_length, m_tdata[26:19]);
                check_field("status", {5'd0, want.status}, {5'd0, m_tdata[29:27]});
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        no_gaps      = 1'b0;
        rx_sent      = 0;
        mismatch_cnt = 0;
        dly_bytes[0] = 8'd0;
        dly_bytes[1] = 8'd0;
        clear_frame_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_control_codes();
        test_frame_types();
        test_payload_limit();
        test_random_stream();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ashrx_pkg.sv
rtl/core/ashrx_frame.sv
rtl/core/ashrx_out_buf.sv
rtl/core/ash_receive_deframer_core.sv
dv/tb_top.sv
